>>> design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int LIMBS  = 8;
	localparam int LIMB_W = 64;
	localparam int IDXW   = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int CNTW   = $clog2(LIMBS + 1);
	localparam int POSW   = $clog2(LIMB_W);

	typedef logic [IDXW-1:0]   idx_t;
	typedef logic [CNTW-1:0]   cnt_t;
	typedef logic [POSW-1:0]   pos_t;
	typedef logic [LIMB_W-1:0] limb_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MOD_ZERO = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_PREP,
		S_CPB,
		S_EBIT,
		S_SQR,
		S_MUL,
		S_CPA,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_A,
		SEL_B,
		SEL_C
	} rsel_t;

endpackage

>>> design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: square-and-multiply base^exp mod m, limb-serial
// Operands load as n limbs and n result limbs return; an error reply is a single limb.
// Throughput: one operand set at a time; error or zero exponent answers at once.
// Reset: arst_n clears control state only; limb storage is not reset.
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mexp_pkg::LIMB_W-1:0] base_limb,
	input  logic [mexp_pkg::LIMB_W-1:0] exp_limb,
	input  logic [mexp_pkg::LIMB_W-1:0] mod_limb,
	input  logic                        last_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mexp_pkg::LIMB_W-1:0] result_limb,
	output logic                        last_out,
	output logic [1:0]                  status
);

	mexp_pkg::limb_t base_q [mexp_pkg::LIMBS];
	mexp_pkg::limb_t exp_q  [mexp_pkg::LIMBS];
	mexp_pkg::limb_t mod_q  [mexp_pkg::LIMBS];
	mexp_pkg::limb_t acc_q  [mexp_pkg::LIMBS];
	mexp_pkg::limb_t x_q    [mexp_pkg::LIMBS];
	mexp_pkg::limb_t ra_q   [mexp_pkg::LIMBS];
	mexp_pkg::limb_t rb_q   [mexp_pkg::LIMBS];
	mexp_pkg::limb_t rc_q   [mexp_pkg::LIMBS];

	mexp_pkg::state_t state_q, state_d;
	mexp_pkg::rsel_t  sel_q;
	mexp_pkg::cnt_t   cnt_q, n_q;
	mexp_pkg::idx_t   j_q, ylimb_q, el_q, oj_q;
	mexp_pkg::pos_t   bpos_q, epos_q;
	mexp_pkg::limb_t  ysh_q, esh_q;
	logic             ovf_q, modnz_q, expnz_q, m1_q, ez_q;
	logic [1:0]       err_q;
	logic             first_q, started_q, mulp_q, done_q;
	logic             tc_q, rtop_q, b1_q, b2_q, mtop_q;

	logic             in_fire, out_fire, st_ok;
	logic             ovf_now, modnz_now, expnz_now, m1_now;
	mexp_pkg::cnt_t   n_now;
	mexp_pkg::idx_t   nl;
	logic             mm_on, mm_end, cp_on, cp_end, elast;
	mexp_pkg::limb_t  rj, xj, mj, m2j, onej;
	logic [mexp_pkg::LIMB_W:0] tsum, usub, vsub;
	logic [1:0]       ttop;
	logic             uok, vok;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign nl       = mexp_pkg::idx_t'(n_q - 1'b1);

	assign st_ok     = cnt_q < mexp_pkg::CNTW'(mexp_pkg::LIMBS);
	assign ovf_now   = ovf_q || !st_ok;
	assign modnz_now = modnz_q || (st_ok && mod_limb != '0);
	assign expnz_now = expnz_q || (st_ok && exp_limb != '0);
	assign m1_now    = !st_ok ? m1_q :
		(cnt_q == '0) ? (mod_limb == mexp_pkg::LIMB_W'(1)) : (m1_q && mod_limb == '0);
	assign n_now     = st_ok ? cnt_q + 1'b1 : cnt_q;

	assign mm_on  = state_q == mexp_pkg::S_PREP || state_q == mexp_pkg::S_SQR
		|| state_q == mexp_pkg::S_MUL;
	assign mm_end = mm_on && !first_q && j_q == nl && bpos_q == '0 && ylimb_q == '0;
	assign cp_on  = state_q == mexp_pkg::S_CPB || state_q == mexp_pkg::S_CPA;
	assign cp_end = cp_on && j_q == nl;
	assign elast  = el_q == '0 && epos_q == '0;

	// current residue limb, multiplicand limb, modulus and doubled modulus
	always_comb begin
		unique case (sel_q)
			mexp_pkg::SEL_ZERO: rj = '0;
			mexp_pkg::SEL_A:    rj = ra_q[j_q];
			mexp_pkg::SEL_B:    rj = rb_q[j_q];
			mexp_pkg::SEL_C:    rj = rc_q[j_q];
			default:            rj = '0;
		endcase
		onej = (j_q == '0 && !m1_q) ? mexp_pkg::LIMB_W'(1) : '0;
		unique case (state_q)
			mexp_pkg::S_PREP: xj = onej;
			mexp_pkg::S_MUL:  xj = base_q[j_q];
			default:          xj = x_q[j_q];
		endcase
		mj   = mod_q[j_q];
		m2j  = {mj[mexp_pkg::LIMB_W-2:0], mtop_q};
		tsum = {1'b0, rj[mexp_pkg::LIMB_W-2:0], rtop_q}
			+ {1'b0, (ysh_q[mexp_pkg::LIMB_W-1] ? xj : {mexp_pkg::LIMB_W{1'b0}})}
			+ (mexp_pkg::LIMB_W+1)'(tc_q);
		usub = {1'b0, tsum[mexp_pkg::LIMB_W-1:0]} - {1'b0, mj}
			- (mexp_pkg::LIMB_W+1)'(b1_q);
		vsub = {1'b0, tsum[mexp_pkg::LIMB_W-1:0]} - {1'b0, m2j}
			- (mexp_pkg::LIMB_W+1)'(b2_q);
		ttop = {1'b0, rj[mexp_pkg::LIMB_W-1]} + {1'b0, tsum[mexp_pkg::LIMB_W]};
		uok  = ttop >= {1'b0, usub[mexp_pkg::LIMB_W]};
		vok  = ttop >= ({1'b0, mj[mexp_pkg::LIMB_W-1]} + {1'b0, vsub[mexp_pkg::LIMB_W]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		result_limb = '0;
		last_out    = 1'b0;
		status      = mexp_pkg::STATUS_OK;
		unique case (state_q)
			mexp_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && last_in) begin
					if (ovf_now || !modnz_now || !expnz_now) begin
						state_d = mexp_pkg::S_OUT;
					end else begin
						state_d = mexp_pkg::S_PREP;
					end
				end
			end
			mexp_pkg::S_PREP: begin
				if (mm_end) state_d = mexp_pkg::S_CPB;
			end
			mexp_pkg::S_CPB: begin
				if (cp_end) state_d = mexp_pkg::S_EBIT;
			end
			mexp_pkg::S_EBIT: begin
				if (started_q || esh_q[mexp_pkg::LIMB_W-1]) begin
					state_d = mexp_pkg::S_SQR;
				end else if (elast) begin
					state_d = mexp_pkg::S_OUT;
				end
			end
			mexp_pkg::S_SQR, mexp_pkg::S_MUL: begin
				if (mm_end) state_d = mexp_pkg::S_CPA;
			end
			mexp_pkg::S_CPA: begin
				if (cp_end) begin
					priority if (mulp_q) state_d = mexp_pkg::S_MUL;
					else if (done_q)     state_d = mexp_pkg::S_OUT;
					else                 state_d = mexp_pkg::S_EBIT;
				end
			end
			mexp_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (err_q != mexp_pkg::STATUS_OK) begin
					last_out = 1'b1;
					status   = err_q;
				end else begin
					last_out    = oj_q == nl;
					result_limb = ez_q ? ((oj_q == '0) ? mexp_pkg::LIMB_W'(1) : '0)
						: acc_q[oj_q];
				end
				if (out_ready && last_out) state_d = mexp_pkg::S_LOAD;
			end
			default: state_d = mexp_pkg::S_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			modnz_q   <= 1'b0;
			expnz_q   <= 1'b0;
			m1_q      <= 1'b0;
			ez_q      <= 1'b0;
			err_q     <= mexp_pkg::STATUS_OK;
			first_q   <= 1'b0;
			started_q <= 1'b0;
			mulp_q    <= 1'b0;
			done_q    <= 1'b0;
			sel_q     <= mexp_pkg::SEL_ZERO;
			j_q       <= '0;
			ylimb_q   <= '0;
			bpos_q    <= '0;
			el_q      <= '0;
			epos_q    <= '0;
			oj_q      <= '0;
			tc_q      <= 1'b0;
			rtop_q    <= 1'b0;
			b1_q      <= 1'b0;
			b2_q      <= 1'b0;
			mtop_q    <= 1'b0;
		end else begin
			first_q <= (state_d == mexp_pkg::S_PREP || state_d == mexp_pkg::S_SQR
				|| state_d == mexp_pkg::S_MUL) && state_d != state_q;
			if (in_fire) begin
				if (last_in) begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					modnz_q <= 1'b0;
					expnz_q <= 1'b0;
					n_q     <= n_now;
					m1_q    <= m1_now;
					ez_q    <= !expnz_now;
					oj_q    <= '0;
					priority if (ovf_now) err_q <= mexp_pkg::STATUS_OVERFLOW;
					else if (!modnz_now)  err_q <= mexp_pkg::STATUS_MOD_ZERO;
					else                  err_q <= mexp_pkg::STATUS_OK;
				end else begin
					cnt_q   <= n_now;
					ovf_q   <= ovf_now;
					modnz_q <= modnz_now;
					expnz_q <= expnz_now;
					m1_q    <= m1_now;
				end
			end
			if (mm_on) begin
				if (first_q) begin
					sel_q   <= mexp_pkg::SEL_ZERO;
					j_q     <= '0;
					ylimb_q <= nl;
					bpos_q  <= mexp_pkg::pos_t'(mexp_pkg::LIMB_W - 1);
				end else if (j_q == nl) begin
					sel_q  <= vok ? mexp_pkg::SEL_C : (uok ? mexp_pkg::SEL_B : mexp_pkg::SEL_A);
					j_q    <= '0;
					tc_q   <= 1'b0;
					rtop_q <= 1'b0;
					b1_q   <= 1'b0;
					b2_q   <= 1'b0;
					mtop_q <= 1'b0;
					bpos_q <= bpos_q - 1'b1;
					if (bpos_q == '0) ylimb_q <= ylimb_q - 1'b1;
				end else begin
					j_q    <= j_q + 1'b1;
					tc_q   <= tsum[mexp_pkg::LIMB_W];
					rtop_q <= rj[mexp_pkg::LIMB_W-1];
					b1_q   <= usub[mexp_pkg::LIMB_W];
					b2_q   <= vsub[mexp_pkg::LIMB_W];
					mtop_q <= mj[mexp_pkg::LIMB_W-1];
				end
			end
			if (cp_on) j_q <= (j_q == nl) ? '0 : j_q + 1'b1;
			if (state_q == mexp_pkg::S_CPB && cp_end) begin
				el_q      <= nl;
				epos_q    <= mexp_pkg::pos_t'(mexp_pkg::LIMB_W - 1);
				started_q <= 1'b0;
				mulp_q    <= 1'b0;
			end
			if (state_q == mexp_pkg::S_CPA && cp_end) mulp_q <= 1'b0;
			if (state_q == mexp_pkg::S_EBIT) begin
				done_q <= elast;
				mulp_q <= esh_q[mexp_pkg::LIMB_W-1];
				if (esh_q[mexp_pkg::LIMB_W-1]) started_q <= 1'b1;
				epos_q <= epos_q - 1'b1;
				if (epos_q == '0) el_q <= el_q - 1'b1;
			end
			if (state_q == mexp_pkg::S_OUT && out_fire) oj_q <= oj_q + 1'b1;
		end
	end

	// limb storage and shift registers
	always_ff @(posedge clk) begin
		if (in_fire && st_ok) begin
			base_q[mexp_pkg::idx_t'(cnt_q)] <= base_limb;
			exp_q[mexp_pkg::idx_t'(cnt_q)]  <= exp_limb;
			mod_q[mexp_pkg::idx_t'(cnt_q)]  <= mod_limb;
		end
		if (mm_on) begin
			if (first_q) begin
				ysh_q <= (state_q == mexp_pkg::S_PREP) ? base_q[nl] : acc_q[nl];
			end else begin
				ra_q[j_q] <= tsum[mexp_pkg::LIMB_W-1:0];
				rb_q[j_q] <= usub[mexp_pkg::LIMB_W-1:0];
				rc_q[j_q] <= vsub[mexp_pkg::LIMB_W-1:0];
				if (j_q == nl) begin
					if (bpos_q == '0) begin
						ysh_q <= (state_q == mexp_pkg::S_PREP) ? base_q[ylimb_q - 1'b1]
							: acc_q[ylimb_q - 1'b1];
					end else begin
						ysh_q <= {ysh_q[mexp_pkg::LIMB_W-2:0], 1'b0};
					end
				end
			end
		end
		if (state_q == mexp_pkg::S_CPB) begin
			base_q[j_q] <= rj;
			acc_q[j_q]  <= onej;
			x_q[j_q]    <= onej;
			if (cp_end) esh_q <= exp_q[nl];
		end
		if (state_q == mexp_pkg::S_CPA) begin
			acc_q[j_q] <= rj;
			x_q[j_q]   <= rj;
		end
		if (state_q == mexp_pkg::S_EBIT) begin
			esh_q <= (epos_q == '0 && el_q != '0) ? exp_q[el_q - 1'b1]
				: {esh_q[mexp_pkg::LIMB_W-2:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes active together");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mexp_pkg::CNTW'(mexp_pkg::LIMBS))
		else $error("load count beyond capacity");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != mexp_pkg::STATUS_OK) |-> (last_out && result_limb == '0))
		else $error("error reply not a single zero limb");
	a_sel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mm_on && first_q) |=> (sel_q == mexp_pkg::SEL_ZERO && j_q == '0))
		else $error("multiplication did not start from zero");
`endif

endmodule
